### hw/rtl/hse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hse_pkg
// Shared constants and types for the sort engine and its chain of cells.
// ----------------------------------------------------------------------------
package hse_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int DATA_W    = 32;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

    // Contents of one cell of the chain.
    typedef struct packed {
        logic                     occ;
        logic signed [DATA_W-1:0] val;
    } slot_t;

    // A word travelling to the right during loading.
    typedef struct packed {
        logic                     vld;
        logic signed [DATA_W-1:0] val;
    } token_t;

    // Control shared by all cells.
    typedef struct packed {
        logic shift;
        logic descending;
    } cell_ctrl_t;

    // Sequencer states, one-hot.
    typedef enum logic [2:0] {
        ST_LOAD  = 3'b001,
        ST_FLUSH = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

endpackage

### hw/rtl/hse_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hse_cell
// One cell of the sorting chain: keeps the better of its word and the
// arriving word, hands the other on, or shifts towards the head on output.
// ----------------------------------------------------------------------------
module hse_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  hse_pkg::cell_ctrl_t ctrl,
    input  hse_pkg::token_t    tok_in,
    input  hse_pkg::slot_t     right_slot,
    output hse_pkg::slot_t     slot,
    output hse_pkg::token_t    tok_out
);
    import hse_pkg::*;

    logic                     occ_reg, occ_next;
    logic signed [DATA_W-1:0] val_reg, val_next;
    logic                     pass_vld_reg, pass_vld_next;
    logic signed [DATA_W-1:0] pass_val_reg, pass_val_next;
    logic                     ranks_first;
    logic                     keep_tok;

    always_comb
    begin
        ranks_first   = ctrl.descending ? (tok_in.val > val_reg) : (tok_in.val < val_reg);
        keep_tok      = !occ_reg || ranks_first;
        occ_next      = occ_reg;
        val_next      = val_reg;
        pass_vld_next = 1'b0;
        pass_val_next = pass_val_reg;
        if (ctrl.shift)
        begin
            occ_next = right_slot.occ;
            val_next = right_slot.val;
        end
        else if (tok_in.vld)
        begin
            occ_next      = 1'b1;
            val_next      = keep_tok ? tok_in.val : val_reg;
            pass_vld_next = occ_reg;
            pass_val_next = keep_tok ? val_reg : tok_in.val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg      <= 1'b0;
            pass_vld_reg <= 1'b0;
        end
        else
        begin
            occ_reg      <= occ_next;
            pass_vld_reg <= pass_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg      <= val_next;
        pass_val_reg <= pass_val_next;
    end

    assign slot.occ    = occ_reg;
    assign slot.val    = val_reg;
    assign tok_out.vld = pass_vld_reg;
    assign tok_out.val = pass_val_reg;

endmodule

### hw/rtl/heap_sort_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heap_sort_engine
// Collects a set of signed words and returns them sorted, ascending or
// descending, with a last marker and an overflow flag on every result.
// ----------------------------------------------------------------------------
//
//  Channel   Dir   Handshake             Contents
//  s_axis    in    s_tvalid/s_tready     tdata: value[31:0]; tlast: last_in
//  m_axis    out   m_tvalid/m_tready     tdata: sorted_value[31:0];
//                                        tlast: last_out; tuser: overflow
//  cfg       in    cfg_valid/cfg_ready   cfg_data: descending
//
// During loading each word enters the head of a chain of MAX_ITEMS cells
// and ripples right one cell per cycle until it settles. After the final
// word the engine waits until every ripple has settled, and then emits
// one result per cycle while m_tready is high, by shifting the chain
// towards the head. While results are pending the input is not ready.
// Reset empties every cell at once; there is no clearing pass.
// Words beyond the capacity are accepted and discarded, and the set's
// results then carry the overflow flag.
//
module heap_sort_engine (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [hse_pkg::DATA_W-1:0] s_tdata,  // value[31:0]
    input  logic                       s_tlast,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [hse_pkg::DATA_W-1:0] m_tdata,  // sorted_value[31:0]
    output logic                       m_tlast,
    output logic                       m_tuser,  // overflow
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic                       cfg_data
);
    import hse_pkg::*;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             dropped_reg, dropped_next;
    logic             desc_reg;

    slot_t            slots [MAX_ITEMS];
    token_t           toks  [MAX_ITEMS];
    token_t           head_tok;
    cell_ctrl_t       ctrl;
    logic [MAX_ITEMS-1:0] tok_vld;
    logic             tok_any;
    logic             in_hs;
    logic             out_hs;
    logic             has_room;

    // The register should only be written between sets; the block itself does not enforce this.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            desc_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            desc_reg <= cfg_data;
        end
    end

    assign s_tready = (state_reg == ST_LOAD);
    assign in_hs    = s_tvalid && s_tready;
    assign has_room = (count_reg < CNT_W'(MAX_ITEMS));

    // The head of the chain is fed straight from the input word.
    assign head_tok.vld = in_hs && has_room;
    assign head_tok.val = signed'(s_tdata);

    // Results are read from the head cell; the word behind it tells
    // whether this is the final one.
    assign m_tvalid = (state_reg == ST_DRAIN) && slots[0].occ;
    assign m_tdata  = slots[0].val;
    assign m_tlast  = (MAX_ITEMS > 1) ? !slots[1].occ : 1'b1;
    assign m_tuser  = dropped_reg;
    assign out_hs   = m_tvalid && m_tready;

    assign ctrl.shift      = (state_reg == ST_DRAIN) && m_tready;
    assign ctrl.descending = desc_reg;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ITEMS; gi++)
        begin : g_cell
            token_t left_tok;
            slot_t  right_slot;

            if (gi == 0)
            begin : g_head
                assign left_tok = head_tok;
            end
            else
            begin : g_body
                assign left_tok = toks[gi-1];
            end

            if (gi == MAX_ITEMS - 1)
            begin : g_tail
                assign right_slot = '0;
            end
            else
            begin : g_inner
                assign right_slot = slots[gi+1];
            end

            hse_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .tok_in     (left_tok),
                .right_slot (right_slot),
                .slot       (slots[gi]),
                .tok_out    (toks[gi])
            );

            assign tok_vld[gi] = toks[gi].vld;
        end
    endgenerate

    // Any word still travelling along the chain.
    assign tok_any = |tok_vld;

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_hs)
                begin
                    if (has_room)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (s_tlast)
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!tok_any)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (out_hs && m_tlast)
                begin
                    state_next   = ST_LOAD;
                    count_next   = '0;
                    dropped_next = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
        end
    end

    // The stored count never passes the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ITEMS))
        else $error("word count exceeds capacity");

    // Results are only shifted out once every word has settled.
    a_settled_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> !tok_any)
        else $error("word still travelling while draining");

    // Draining always starts with a word in the head cell.
    a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH && !tok_any) |=> slots[0].occ)
        else $error("chain empty at start of drain");

    // The final result returns the engine to an empty, loading state.
    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_hs && m_tlast) |=> (state_reg == ST_LOAD && count_reg == '0
                                 && !dropped_reg && !slots[0].occ))
        else $error("engine not cleared after final result");

endmodule
